// ===== hdl/notification_stream_parser_macros.svh =====
// Assertion macros for the notification stream parser.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef NOTIFICATION_STREAM_PARSER_MACROS_SVH
`define NOTIFICATION_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nsp_pkg.sv =====
// Types and constants shared by the notification stream parser.
// No dependencies.
package nsp_pkg;

  // Header field sizes in bytes.
  localparam int LenFieldBytes  = 4;
  localparam int SampleHdrBytes = 8;
  localparam int StampHdrBytes  = 12;

  // Result queue geometry.
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CountW    = PtrW + 1;

  typedef enum logic [2:0] {
    PH_LEN        = 3'd0,
    PH_STAMPS     = 3'd1,
    PH_STAMP_HDR  = 3'd2,
    PH_SAMPLE_HDR = 3'd3,
    PH_DATA       = 3'd4,
    PH_DONE       = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_SHORT        = 3'd1,
    ERR_LEN_OVERRUN  = 3'd2,
    ERR_STAMP_HDR    = 3'd3,
    ERR_SAMPLE_HDR   = 3'd4,
    ERR_DATA_OVERRUN = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] handle;
    logic [63:0] timestamp;
    logic [31:0] sample_size;
    logic [31:0] byte_index;
    logic [7:0]  sample_byte;
    logic        sample_end;
    logic        frame_ok;
    err_e        error_kind;
    logic        last;
  } result_t;

endpackage

// ===== hdl/notification_stream_parser.sv =====
// Top level of the notification stream parser: byte-serial frame parser
// with a small result queue. Depends on nsp_pkg and the macros header.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o  | data_byte_i, total_len_i
//   out     | output    | out_valid_o / out_ready_i| kind_o ... last_o
//
// One payload word is accepted per cycle while in_ready_o is high. Its results are
// written straight into a four-entry result queue. A word causes at most two results
// (a sample result plus the frame status on the last word), so in_ready_o stays high
// while the queue has two free entries. With the output side taking a result every
// cycle the sustained rate is one word per cycle. Reset clears the parser state and
// empties the queue.
`include "notification_stream_parser_macros.svh"

module notification_stream_parser #(
  parameter int FRAME_LEN_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] total_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] handle_o,
  output logic [63:0] timestamp_o,
  output logic [31:0] sample_size_o,
  output logic [31:0] byte_index_o,
  output logic [7:0]  sample_byte_o,
  output logic        sample_end_o,
  output logic        frame_ok_o,
  output logic [2:0]  error_kind_o,
  output logic        last_o
);

  localparam int LW = FRAME_LEN_BITS;
  // Width for length checks: a 32-bit size added to a position, plus margin.
  localparam int CW = 34;

  // Parser state.
  logic [LW-1:0]        pos_q, pos_d;
  nsp_pkg::phase_e      phase_q, phase_d;
  logic [31:0]          field_q, field_d;
  logic [3:0]           fcnt_q, fcnt_d;
  logic [31:0]          stamps_q, stamps_d;
  logic [31:0]          samples_q, samples_d;
  logic [63:0]          ts_q, ts_d;
  logic [31:0]          handle_q, handle_d;
  logic [31:0]          size_q, size_d;
  logic [31:0]          idx_q, idx_d;
  nsp_pkg::err_e        err_q, err_d;

  // Result queue.
  nsp_pkg::result_t             fifo_q [nsp_pkg::FifoDepth];
  logic [nsp_pkg::PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [nsp_pkg::CountW-1:0]   count_q, count_d;
  nsp_pkg::result_t             rd_res;

  logic            in_accept, out_accept;
  logic [LW-1:0]   total;
  logic [LW:0]     nextp;
  logic            is_last;
  logic [31:0]     fld_new;
  logic            push_a, push_b;
  nsp_pkg::result_t res_a, res_b;
  logic            ni_go;
  logic [31:0]     ni_samples, ni_stamps;
  nsp_pkg::err_e   fin_err;

  assign in_accept  = in_valid_i && in_ready_o;
  assign out_accept = out_valid_o && out_ready_i;

  assign total   = total_len_i[LW-1:0];
  assign nextp   = {1'b0, pos_q} + (LW+1)'(1);
  assign is_last = nextp >= {1'b0, total};

  // The current field with this word placed in its byte lane. Every field built here
  // is 32 bits, so the low two bits of the byte count select the lane.
  always_comb begin
    fld_new = field_q;
    fld_new[{fcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
  end

  // Next-state logic for one accepted word.
  always_comb begin
    pos_d      = pos_q;
    phase_d    = phase_q;
    field_d    = field_q;
    fcnt_d     = fcnt_q;
    stamps_d   = stamps_q;
    samples_d  = samples_q;
    ts_d       = ts_q;
    handle_d   = handle_q;
    size_d     = size_q;
    idx_d      = idx_q;
    err_d      = err_q;
    push_a     = 1'b0;
    push_b     = 1'b0;
    res_a      = '0;
    res_b      = '0;
    ni_go      = 1'b0;
    ni_samples = samples_q;
    ni_stamps  = stamps_q;
    fin_err    = nsp_pkg::ERR_NONE;

    if (in_accept) begin
      if (err_q == nsp_pkg::ERR_NONE) begin
        unique case (phase_q)
          nsp_pkg::PH_LEN: begin
            if (fcnt_q == 4'd0 && total < LW'(8)) begin
              err_d   = nsp_pkg::ERR_SHORT;
              phase_d = nsp_pkg::PH_DONE;
            end else begin
              field_d = fld_new;
              fcnt_d  = fcnt_q + 4'd1;
              if (fcnt_q == 4'(nsp_pkg::LenFieldBytes - 1)) begin
                if (CW'(nsp_pkg::LenFieldBytes) + CW'(fld_new) > CW'(total)) begin
                  err_d   = nsp_pkg::ERR_LEN_OVERRUN;
                  phase_d = nsp_pkg::PH_DONE;
                end else begin
                  field_d = '0;
                  fcnt_d  = '0;
                  phase_d = nsp_pkg::PH_STAMPS;
                end
              end
            end
          end
          nsp_pkg::PH_STAMPS: begin
            field_d = fld_new;
            fcnt_d  = fcnt_q + 4'd1;
            if (fcnt_q == 4'(nsp_pkg::LenFieldBytes - 1)) begin
              ni_go      = 1'b1;
              ni_stamps  = fld_new;
              ni_samples = '0;
            end
          end
          nsp_pkg::PH_STAMP_HDR: begin
            if (fcnt_q < 4'd8) begin
              ts_d[{fcnt_q[2:0], 3'b000} +: 8] = data_byte_i;
            end else begin
              field_d = fld_new;
            end
            fcnt_d = fcnt_q + 4'd1;
            if (fcnt_q == 4'(nsp_pkg::StampHdrBytes - 1)) begin
              ni_go      = 1'b1;
              ni_samples = fld_new;
            end
          end
          nsp_pkg::PH_SAMPLE_HDR: begin
            if (fcnt_q < 4'd4) begin
              handle_d[{fcnt_q[1:0], 3'b000} +: 8] = data_byte_i;
            end else begin
              field_d = fld_new;
            end
            fcnt_d = fcnt_q + 4'd1;
            if (fcnt_q == 4'(nsp_pkg::SampleHdrBytes - 1)) begin
              size_d = fld_new;
              idx_d  = '0;
              if (CW'(nextp) + CW'(fld_new) > CW'(total)) begin
                err_d   = nsp_pkg::ERR_DATA_OVERRUN;
                phase_d = nsp_pkg::PH_DONE;
              end else if (fld_new == 32'd0) begin
                // An empty sample gives a single marker result.
                push_a            = 1'b1;
                res_a.kind        = nsp_pkg::KIND_EMPTY;
                res_a.handle      = handle_q;
                res_a.timestamp   = ts_q;
                res_a.sample_size = '0;
                res_a.sample_end  = 1'b1;
                res_a.error_kind  = nsp_pkg::ERR_NONE;
                res_a.last        = !is_last;
                ni_go             = 1'b1;
              end else begin
                field_d = '0;
                fcnt_d  = '0;
                phase_d = nsp_pkg::PH_DATA;
              end
            end
          end
          nsp_pkg::PH_DATA: begin
            push_a            = 1'b1;
            res_a.kind        = nsp_pkg::KIND_DATA;
            res_a.handle      = handle_q;
            res_a.timestamp   = ts_q;
            res_a.sample_size = size_q;
            res_a.byte_index  = idx_q;
            res_a.sample_byte = data_byte_i;
            res_a.sample_end  = (idx_q + 32'd1) == size_q;
            res_a.error_kind  = nsp_pkg::ERR_NONE;
            res_a.last        = !is_last;
            idx_d             = idx_q + 32'd1;
            ni_go             = (idx_q + 32'd1) == size_q;
          end
          default: begin
          end
        endcase

        // Pick the next item: another sample of this stamp, the next stamp,
        // or nothing more. Headers that cannot fit in the frame fail here.
        if (ni_go) begin
          field_d   = '0;
          fcnt_d    = '0;
          samples_d = ni_samples;
          stamps_d  = ni_stamps;
          if (ni_samples != 32'd0) begin
            if (CW'(nextp) + CW'(nsp_pkg::SampleHdrBytes) > CW'(total)) begin
              err_d   = nsp_pkg::ERR_SAMPLE_HDR;
              phase_d = nsp_pkg::PH_DONE;
            end else begin
              samples_d = ni_samples - 32'd1;
              handle_d  = '0;
              phase_d   = nsp_pkg::PH_SAMPLE_HDR;
            end
          end else if (ni_stamps != 32'd0) begin
            if (CW'(nextp) + CW'(nsp_pkg::StampHdrBytes) > CW'(total)) begin
              err_d   = nsp_pkg::ERR_STAMP_HDR;
              phase_d = nsp_pkg::PH_DONE;
            end else begin
              stamps_d = ni_stamps - 32'd1;
              ts_d     = '0;
              phase_d  = nsp_pkg::PH_STAMP_HDR;
            end
          end else begin
            phase_d = nsp_pkg::PH_DONE;
          end
        end
      end

      if (is_last) begin
        // A frame that ends inside a pending item reports where it stopped.
        fin_err = err_d;
        if (err_d == nsp_pkg::ERR_NONE && phase_d != nsp_pkg::PH_DONE) begin
          priority case (phase_d)
            nsp_pkg::PH_LEN, nsp_pkg::PH_STAMPS: fin_err = nsp_pkg::ERR_SHORT;
            nsp_pkg::PH_STAMP_HDR:               fin_err = nsp_pkg::ERR_STAMP_HDR;
            nsp_pkg::PH_SAMPLE_HDR:              fin_err = nsp_pkg::ERR_SAMPLE_HDR;
            default:                             fin_err = nsp_pkg::ERR_DATA_OVERRUN;
          endcase
        end
        push_b           = 1'b1;
        res_b.kind       = nsp_pkg::KIND_STATUS;
        res_b.frame_ok   = fin_err == nsp_pkg::ERR_NONE;
        res_b.error_kind = fin_err;
        res_b.last       = 1'b1;

        // Back to the reset state for the next frame.
        pos_d     = '0;
        phase_d   = nsp_pkg::PH_LEN;
        field_d   = '0;
        fcnt_d    = '0;
        stamps_d  = '0;
        samples_d = '0;
        ts_d      = '0;
        handle_d  = '0;
        size_d    = '0;
        idx_d     = '0;
        err_d     = nsp_pkg::ERR_NONE;
      end else begin
        pos_d = nextp[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= nsp_pkg::PH_LEN;
      field_q   <= '0;
      fcnt_q    <= '0;
      stamps_q  <= '0;
      samples_q <= '0;
      ts_q      <= '0;
      handle_q  <= '0;
      size_q    <= '0;
      idx_q     <= '0;
      err_q     <= nsp_pkg::ERR_NONE;
    end else begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      field_q   <= field_d;
      fcnt_q    <= fcnt_d;
      stamps_q  <= stamps_d;
      samples_q <= samples_d;
      ts_q      <= ts_d;
      handle_q  <= handle_d;
      size_q    <= size_d;
      idx_q     <= idx_d;
      err_q     <= err_d;
    end
  end

  // Result queue. When a word gives two results, the status goes in second.
  assign in_ready_o  = count_q <= nsp_pkg::CountW'(nsp_pkg::FifoDepth - 2);
  assign out_valid_o = count_q != '0;

  always_comb begin
    wr_d    = wr_q + nsp_pkg::PtrW'({1'b0, push_a} + {1'b0, push_b});
    rd_d    = rd_q + nsp_pkg::PtrW'(out_accept);
    count_d = count_q + nsp_pkg::CountW'({1'b0, push_a} + {1'b0, push_b})
              - nsp_pkg::CountW'(out_accept);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      fifo_q[wr_q] <= res_a;
    end
    if (push_b) begin
      fifo_q[push_a ? wr_q + nsp_pkg::PtrW'(1) : wr_q] <= res_b;
    end
  end

  assign rd_res        = fifo_q[rd_q];
  assign kind_o        = rd_res.kind;
  assign handle_o      = rd_res.handle;
  assign timestamp_o   = rd_res.timestamp;
  assign sample_size_o = rd_res.sample_size;
  assign byte_index_o  = rd_res.byte_index;
  assign sample_byte_o = rd_res.sample_byte;
  assign sample_end_o  = rd_res.sample_end;
  assign frame_ok_o    = rd_res.frame_ok;
  assign error_kind_o  = rd_res.error_kind;
  assign last_o        = rd_res.last;

  // A recorded error always parks the parser until the frame ends.
  `NSP_ASSERT_IMP(a_err_parks, err_q != nsp_pkg::ERR_NONE, phase_q == nsp_pkg::PH_DONE, "error without done phase")
  // The last word of a frame returns the parser to its start state.
  `NSP_ASSERT_NEXT(a_frame_restart, in_accept && is_last, (pos_q == '0) && (phase_q == nsp_pkg::PH_LEN) && (err_q == nsp_pkg::ERR_NONE), "parser not reset after frame end")
  // A frame status is always the final result of its word.
  `NSP_ASSERT_IMP(a_status_last, out_valid_o && (rd_res.kind == nsp_pkg::KIND_STATUS), last_o, "status result without last")

endmodule

// ===== dv/tb_notification_stream_parser.sv =====
// Self-checking testbench for notification_stream_parser: byte-serial frames in, sample and
// status results out, both sides handshaked with random idling.
// Depends on nsp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_notification_stream_parser;

  // The smallest frame that can parse is the length field plus the stamp count.
  localparam int MinFrameBytes = 2 * nsp_pkg::LenFieldBytes;
  localparam int RandomWords   = 1680;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i   = 8'h00;
  logic [31:0] total_len_i   = 32'd1;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] handle_o;
  logic [63:0] timestamp_o;
  logic [31:0] sample_size_o;
  logic [31:0] byte_index_o;
  logic [7:0]  sample_byte_o;
  logic        sample_end_o;
  logic        frame_ok_o;
  logic [2:0]  error_kind_o;
  logic        last_o;

  notification_stream_parser u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .total_len_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .handle_o,
    .timestamp_o,
    .sample_size_o,
    .byte_index_o,
    .sample_byte_o,
    .sample_end_o,
    .frame_ok_o,
    .error_kind_o,
    .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results the parser owes us, oldest first.
  nsp_pkg::result_t parser_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned words_accepted = 0;

  // Idle rates in percent for the input side and for the result side.
  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned stall_left    = 0;

  // Frame under construction; the send task walks through it byte by byte.
  logic [7:0]  frame_q[$];
  // Offsets of every count and size field in frame_q, used to corrupt one of them.
  int unsigned count_pos_q[$];

  // Mirror of the parser state.
  nsp_pkg::phase_e parse_phase;
  nsp_pkg::err_e   parse_error;
  logic [31:0] parse_pos;
  logic [63:0] parse_field;
  int unsigned parse_field_bytes;
  logic [31:0] parse_stamps_left;
  logic [31:0] parse_samples_left;
  logic [63:0] parse_timestamp;
  logic [31:0] parse_handle;
  logic [31:0] parse_size;
  logic [31:0] parse_index;

  function automatic void clear_parse_state();
    parse_phase        = nsp_pkg::PH_LEN;
    parse_error        = nsp_pkg::ERR_NONE;
    parse_pos          = '0;
    parse_field        = '0;
    parse_field_bytes  = 0;
    parse_stamps_left  = '0;
    parse_samples_left = '0;
    parse_timestamp    = '0;
    parse_handle       = '0;
    parse_size         = '0;
    parse_index        = '0;
  endfunction

  // Once an error is latched the rest of the frame is skipped until its last word.
  function automatic void abort_parse(input nsp_pkg::err_e code);
    parse_error = code;
    parse_phase = nsp_pkg::PH_DONE;
  endfunction

  // Pick the next header starting at byte offset p. A header is only entered when it fits
  // in the frame, so no sample data is released before its length has been checked.
  function automatic void advance_item(input logic [63:0] p, input logic [63:0] tot);
    parse_field       = '0;
    parse_field_bytes = 0;
    if (parse_samples_left != 0) begin
      if (p + nsp_pkg::SampleHdrBytes > tot) begin
        abort_parse(nsp_pkg::ERR_SAMPLE_HDR);
      end else begin
        parse_samples_left--;
        parse_handle = '0;
        parse_phase  = nsp_pkg::PH_SAMPLE_HDR;
      end
    end else if (parse_stamps_left != 0) begin
      if (p + nsp_pkg::StampHdrBytes > tot) begin
        abort_parse(nsp_pkg::ERR_STAMP_HDR);
      end else begin
        parse_stamps_left--;
        parse_timestamp = '0;
        parse_phase     = nsp_pkg::PH_STAMP_HDR;
      end
    end else begin
      // Anything after the last announced stamp is ignored.
      parse_phase = nsp_pkg::PH_DONE;
    end
  endfunction

  function automatic nsp_pkg::result_t sample_result(input nsp_pkg::kind_e k,
                                                     input logic [7:0] b,
                                                     input logic [31:0] idx,
                                                     input logic at_end);
    nsp_pkg::result_t r;
    r             = '0;
    r.kind        = k;
    r.handle      = parse_handle;
    r.timestamp   = parse_timestamp;
    r.sample_size = parse_size;
    r.byte_index  = idx;
    r.sample_byte = b;
    r.sample_end  = at_end;
    return r;
  endfunction

  // Work out what one accepted word makes the parser emit and queue it up.
  function automatic void parse_notification_word(input logic [7:0] b,
                                                   input logic [31:0] tot_in);
    logic [63:0]      tot;
    logic [63:0]      nextp;
    logic             at_end;
    nsp_pkg::result_t outs[2];
    nsp_pkg::result_t r;
    int               n;
    tot   = {32'd0, tot_in};
    nextp = {32'd0, parse_pos} + 64'd1;
    n     = 0;

    if (parse_error == nsp_pkg::ERR_NONE) begin
      case (parse_phase)
        nsp_pkg::PH_LEN: begin
          // The total length is only judged on the first word of the frame.
          if (parse_field_bytes == 0 && tot < MinFrameBytes) begin
            abort_parse(nsp_pkg::ERR_SHORT);
          end else begin
            parse_field[8*parse_field_bytes +: 8] = b;
            parse_field_bytes++;
            if (parse_field_bytes >= nsp_pkg::LenFieldBytes) begin
              if (nsp_pkg::LenFieldBytes + parse_field > tot) begin
                abort_parse(nsp_pkg::ERR_LEN_OVERRUN);
              end else begin
                parse_field       = '0;
                parse_field_bytes = 0;
                parse_phase       = nsp_pkg::PH_STAMPS;
              end
            end
          end
        end
        nsp_pkg::PH_STAMPS: begin
          parse_field[8*parse_field_bytes +: 8] = b;
          parse_field_bytes++;
          if (parse_field_bytes >= nsp_pkg::LenFieldBytes) begin
            parse_stamps_left  = parse_field[31:0];
            parse_samples_left = '0;
            advance_item(nextp, tot);
          end
        end
        nsp_pkg::PH_STAMP_HDR: begin
          // Eight timestamp bytes, then the sample count.
          if (parse_field_bytes < 8) parse_timestamp[8*parse_field_bytes +: 8] = b;
          else parse_field[8*(parse_field_bytes - 8) +: 8] = b;
          parse_field_bytes++;
          if (parse_field_bytes >= nsp_pkg::StampHdrBytes) begin
            parse_samples_left = parse_field[31:0];
            advance_item(nextp, tot);
          end
        end
        nsp_pkg::PH_SAMPLE_HDR: begin
          // Four handle bytes, then the sample size.
          if (parse_field_bytes < 4) parse_handle[8*parse_field_bytes +: 8] = b;
          else parse_field[8*(parse_field_bytes - 4) +: 8] = b;
          parse_field_bytes++;
          if (parse_field_bytes >= nsp_pkg::SampleHdrBytes) begin
            parse_size  = parse_field[31:0];
            parse_index = '0;
            if (nextp + parse_size > tot) begin
              abort_parse(nsp_pkg::ERR_DATA_OVERRUN);
            end else if (parse_size == 0) begin
              outs[n] = sample_result(nsp_pkg::KIND_EMPTY, 8'h00, 32'd0, 1'b1);
              n++;
              advance_item(nextp, tot);
            end else begin
              parse_field       = '0;
              parse_field_bytes = 0;
              parse_phase       = nsp_pkg::PH_DATA;
            end
          end
        end
        nsp_pkg::PH_DATA: begin
          at_end  = (parse_index + 32'd1 == parse_size);
          outs[n] = sample_result(nsp_pkg::KIND_DATA, b, parse_index, at_end);
          n++;
          parse_index++;
          if (at_end) advance_item(nextp, tot);
        end
        default: begin
        end
      endcase
    end

    // Last word of the frame: a frame cut short inside an item reports where it stopped.
    if (nextp >= tot) begin
      if (parse_error == nsp_pkg::ERR_NONE && parse_phase != nsp_pkg::PH_DONE) begin
        case (parse_phase)
          nsp_pkg::PH_LEN, nsp_pkg::PH_STAMPS: abort_parse(nsp_pkg::ERR_SHORT);
          nsp_pkg::PH_STAMP_HDR:               abort_parse(nsp_pkg::ERR_STAMP_HDR);
          nsp_pkg::PH_SAMPLE_HDR:              abort_parse(nsp_pkg::ERR_SAMPLE_HDR);
          default:                             abort_parse(nsp_pkg::ERR_DATA_OVERRUN);
        endcase
      end
      r            = '0;
      r.kind       = nsp_pkg::KIND_STATUS;
      r.frame_ok   = (parse_error == nsp_pkg::ERR_NONE);
      r.error_kind = parse_error;
      outs[n]      = r;
      n++;
      clear_parse_state();
    end else begin
      parse_pos = nextp[31:0];
    end

    if (n > 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) parser_results_q.push_back(outs[i]);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Present one word and hold it until the parser takes it. Valid is only dropped when a gap
  // follows, so back-to-back words keep valid high without a glitch.
  task automatic send_word(input logic [7:0] b, input logic [31:0] tot);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    total_len_i <= tot;
    do @(posedge clk_i); while (!in_ready_o);
    parse_notification_word(b, tot);
    words_accepted++;
    gap = pick_gap(in_gap_pct);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Send n_words of frame_q, padding with random bytes past its end. Every word but the last
  // carries body_total; the last one carries end_total, which lets a frame end early.
  task automatic send_frame(input int unsigned n_words, input logic [31:0] body_total,
                            input logic [31:0] end_total);
    logic [7:0] b;
    for (int unsigned i = 0; i < n_words; i++) begin
      b = (i < frame_q.size()) ? frame_q[i] : 8'($urandom);
      send_word(b, (i == n_words - 1) ? end_total : body_total);
    end
  endtask

  function automatic void put_le(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) frame_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void patch_le32(input int unsigned at, input logic [31:0] v);
    for (int i = 0; i < 4; i++) frame_q[at + i] = v[8*i +: 8];
  endfunction

  // Random well-formed frame body; the length field is left at zero for the caller.
  function automatic void build_random_frame();
    int unsigned n_stamps;
    int unsigned n_samples;
    int unsigned n_bytes;
    int unsigned pick;
    frame_q.delete();
    count_pos_q.delete();
    pick     = $urandom_range(0, 9);
    n_stamps = (pick == 0) ? 0 : (pick < 6) ? 1 : (pick < 9) ? 2 : 3;
    put_le(64'd0, 4);
    count_pos_q.push_back(frame_q.size());
    put_le(64'(n_stamps), 4);
    for (int s = 0; s < n_stamps; s++) begin
      n_samples = $urandom_range(0, 3);
      put_le({$urandom, $urandom}, 8);
      count_pos_q.push_back(frame_q.size());
      put_le(64'(n_samples), 4);
      for (int k = 0; k < n_samples; k++) begin
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        put_le(64'($urandom), 4);
        count_pos_q.push_back(frame_q.size());
        put_le(64'(n_bytes), 4);
        for (int d = 0; d < n_bytes; d++) frame_q.push_back(8'($urandom));
      end
    end
  endfunction

  // Result side: compare every accepted result and drive ready with random stalls.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    nsp_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parser_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind 0x%0h", $time, kind_o);
        mismatch_count++;
      end else begin
        want = parser_results_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("handle", want.handle, handle_o);
        check_field("timestamp", want.timestamp, timestamp_o);
        check_field("sample_size", want.sample_size, sample_size_o);
        check_field("byte_index", want.byte_index, byte_index_o);
        check_field("sample_byte", want.sample_byte, sample_byte_o);
        check_field("sample_end", want.sample_end, sample_end_o);
        check_field("frame_ok", want.frame_ok, frame_ok_o);
        check_field("error_kind", want.error_kind, error_kind_o);
        check_field("last", want.last, last_o);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = pick_gap(out_stall_pct);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // A total length below the minimum fails on the first word; the rest of the frame is
  // skipped up to its status.
  task automatic test_short_frame();
    frame_q.delete();
    send_frame(1, 32'd1, 32'd1);
    send_frame(7, 32'd7, 32'd7);
  endtask

  // Smallest good frame, then a length field at its maximum.
  task automatic test_length_overrun();
    frame_q.delete();
    put_le(64'd4, 4);
    put_le(64'd0, 4);
    send_frame(8, 32'd8, 32'd8);
    patch_le32(0, 32'hFFFF_FFFF);
    send_frame(8, 32'd8, 32'd8);
  endtask

  // One stamp announced but no room for its header.
  task automatic test_stamp_header_overrun();
    frame_q.delete();
    put_le(64'd4, 4);
    put_le(64'd1, 4);
    send_frame(8, 32'd8, 32'd8);
  endtask

  // One sample announced right at the end of the frame.
  task automatic test_sample_header_overrun();
    frame_q.delete();
    put_le(64'd16, 4);
    put_le(64'd1, 4);
    put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    put_le(64'd1, 4);
    send_frame(20, 32'd20, 32'd20);
  endtask

  // A declared size at its maximum must not release any data.
  task automatic test_data_overrun();
    frame_q.delete();
    put_le(64'd24, 4);
    put_le(64'd1, 4);
    put_le(64'd0, 8);
    put_le(64'd1, 4);
    put_le(64'hFFFF_FFFF, 4);
    put_le(64'hFFFF_FFFF, 4);
    send_frame(28, 32'd28, 32'd28);
  endtask

  // Data and empty samples across two stamps; the frame ends on an empty sample, so its
  // last word gives the marker and the status. A second frame ends on a data word.
  task automatic test_sample_data();
    int unsigned n;
    frame_q.delete();
    put_le(64'd0, 4);
    put_le(64'd2, 4);
    put_le(64'h0123_4567_89AB_CDEF, 8);
    put_le(64'd2, 4);
    put_le(64'd0, 4);
    put_le(64'd0, 4);
    put_le(64'hFFFF_FFFF, 4);
    put_le(64'd3, 4);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h5A);
    put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    put_le(64'd1, 4);
    put_le(64'($urandom), 4);
    put_le(64'd0, 4);
    n = frame_q.size();
    patch_le32(0, 32'(n - 4));
    send_frame(n, 32'(n), 32'(n));

    frame_q.delete();
    put_le(64'd0, 4);
    put_le(64'd1, 4);
    put_le({$urandom, $urandom}, 8);
    put_le(64'd1, 4);
    put_le(64'h8000_0001, 4);
    put_le(64'd1, 4);
    frame_q.push_back(8'hA5);
    n = frame_q.size();
    patch_le32(0, 32'(n - 4));
    send_frame(n, 32'(n), 32'(n));
  endtask

  // The total length shrinks on the last word so the frame stops inside each kind of item,
  // and once after everything announced has been parsed.
  task automatic test_early_end();
    int unsigned cuts[6];
    cuts = '{2, 6, 12, 24, 29, 32};
    frame_q.delete();
    put_le(64'd26, 4);
    put_le(64'd1, 4);
    put_le({$urandom, $urandom}, 8);
    put_le(64'd1, 4);
    put_le(64'($urandom), 4);
    put_le(64'd2, 4);
    put_le(64'($urandom), 2);
    foreach (cuts[i]) begin
      send_frame(cuts[i], 32'hFFFF_FFFF, (i == 2) ? 32'd1 : 32'(cuts[i]));
    end
  endtask

  // Mostly well-formed frames with random content, the rest broken in every way the
  // parser checks for, plus plain noise.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned sel;
    int unsigned n;
    int unsigned cut;
    goal = words_accepted + RandomWords;
    while (words_accepted < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
          1: begin in_gap_pct = 20; out_stall_pct = 20; end
          2: begin in_gap_pct = 0;  out_stall_pct = 50; end
          default: begin in_gap_pct = 50; out_stall_pct = 10; end
        endcase
      end
      build_random_frame();
      n   = frame_q.size();
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        // Good frame, sometimes with ignored trailing bytes or a smaller length field.
        if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 3);
        patch_le32(0, ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 4) : n - 4);
        send_frame(n, 32'(n), 32'(n));
      end else if (sel < 68) begin
        patch_le32(0, $urandom_range(0, 1) ? n - 3 + $urandom_range(0, 8)
                                           : ($urandom | 32'h8000_0000));
        send_frame(n, 32'(n), 32'(n));
      end else if (sel < 78) begin
        // Truncated: the total no longer covers everything announced.
        if (n > MinFrameBytes) n = $urandom_range(MinFrameBytes, n - 1);
        patch_le32(0, n - 4);
        send_frame(n, 32'(n), 32'(n));
      end else if (sel < 84) begin
        patch_le32(count_pos_q[$urandom_range(0, count_pos_q.size() - 1)],
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4));
        patch_le32(0, n - 4);
        send_frame(n, 32'(n), 32'(n));
      end else if (sel < 92) begin
        // Huge total that shrinks on the last word.
        cut = $urandom_range(1, n);
        patch_le32(0, $urandom_range(0, 3) == 0 ? $urandom : n - 4);
        send_frame(cut, $urandom | 32'h0000_1000,
                   $urandom_range((cut > 3) ? cut - 2 : 1, cut));
      end else begin
        frame_q.delete();
        n = $urandom_range(1, 24);
        send_frame(n, 32'(n), 32'(n));
      end
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    clear_parse_state();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frame();
    test_length_overrun();
    test_stamp_header_overrun();
    test_sample_header_overrun();
    test_data_overrun();
    test_sample_data();
    test_early_end();
    test_random_frames();
    in_valid_i <= 1'b0;

    // Let every owed result come out, then watch a little longer for strays.
    drain_cycles = 0;
    while (parser_results_q.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (parser_results_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               parser_results_q.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("notification_stream_parser verification clean");
    end else begin
      $display("notification_stream_parser verification failed");
    end
    $finish;
  end

  // Watchdog, well above the slowest correct run.
  initial begin
    #8_000_000;
    $display("notification_stream_parser verification failed");
    $finish;
  end

endmodule
